// File: rtl/grid_boundary_cell_extractor_unit_macros.svh
// Assertion helpers shared by the RTL.
`ifndef GRID_BOUNDARY_CELL_EXTRACTOR_UNIT_MACROS_SVH
`define GRID_BOUNDARY_CELL_EXTRACTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GBCE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GBCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gbce_pkg.sv
package gbce_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int NEIGHBOURS = 4;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SIZE_W = 9;
    localparam int TILE_W = 16;
    localparam int OUT_W  = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;

    localparam int OCC_W = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [SIZE_W-1:0] RST_GRID_WIDTH  = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] RST_GRID_HEIGHT = SIZE_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [OUT_W-1:0] cell_row;
        logic [OUT_W-1:0] cell_col;
        logic             last_in_run;
    } t_result;

endpackage

// File: rtl/gbce_intf.sv
interface gbce_in_if import gbce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TILE_W-1:0] tile_id;

    modport source (output valid, output tile_id, input ready);
    modport sink   (input valid, input tile_id, output ready);
endinterface

interface gbce_out_if import gbce_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] cell_row;
    logic [OUT_W-1:0] cell_col;
    logic             last_in_run;

    modport source (output valid, output cell_row, output cell_col, output last_in_run,
                    input ready);
    modport sink   (input valid, input cell_row, input cell_col, input last_in_run,
                    output ready);
endinterface

interface gbce_cfg_if import gbce_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/grid_boundary_cell_extractor_unit.sv
// Results of a request are written into the output queue when the request is accepted.
// Throughput: one request per cycle, bounded by the line buffer RAM (one write and two
//   registered reads per request); results leave one per cycle through a 4-entry queue,
//   and requests stall while fewer than two queue entries are free.
// Reset: synchronous, active low; clears position counters and queue, loads register
//   defaults (enable 1, width 64, height 64). The line buffer RAM is not cleared.
`include "grid_boundary_cell_extractor_unit_macros.svh"

module grid_boundary_cell_extractor_unit import gbce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gbce_in_if.sink     i_in,
    gbce_out_if.source  o_out,
    gbce_cfg_if.sink    i_cfg
);

    logic              r_enable;
    logic [SIZE_W-1:0] r_grid_width;
    logic [SIZE_W-1:0] r_grid_height;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic              r_left;

    t_result            r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_CW-1:0] r_cnt;

    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic             in_acc;
    logic             out_acc;
    logic             cfg_acc;
    logic             cur;
    logic             self_occ;
    logic             up_occ;
    logic             right_occ;
    logic             last_row;
    logic             row_end;
    logic             border;
    logic [2:0]       cnt;
    logic             v_up;
    logic             v_cur;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [1:0]       n_push;
    t_result          res_up;
    t_result          res_cur;
    t_result          push_a;
    t_result          push_b;
    logic [OCC_W-1:0] rd_a;
    logic [OCC_W-1:0] rd_b;

    assign w_m1 = (r_grid_width == '0) ? '0 :
                  (int'(r_grid_width) > MAX_WIDTH) ? COL_W'(MAX_WIDTH - 1) :
                  COL_W'(r_grid_width - 1'b1);
    assign h_m1 = (r_grid_height == '0) ? '0 :
                  (int'(r_grid_height) > MAX_HEIGHT) ? ROW_W'(MAX_HEIGHT - 1) :
                  ROW_W'(r_grid_height - 1'b1);

    assign i_in.ready  = (r_cnt <= FIFO_CW'(FIFO_DEPTH - 2));
    assign i_cfg.ready = 1'b1;
    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;

    // entry layout: bit 1 older row, bit 0 previous row
    assign cur       = (i_in.tile_id != '0);
    assign self_occ  = rd_a[0];
    assign up_occ    = rd_a[1];
    assign right_occ = rd_b[0];

    assign last_row = (r_row >= h_m1);
    assign row_end  = (r_col >= w_m1);
    assign border   = (r_row == ROW_W'(1)) || ((r_row - 1'b1) >= h_m1) ||
                      (r_col == '0) || row_end;
    assign cnt      = 3'(up_occ) + 3'(cur) + 3'(r_left) + 3'(right_occ);

    assign v_up  = r_enable && (r_row != '0) && self_occ && (border || (cnt < 3'(NEIGHBOURS)));
    assign v_cur = r_enable && last_row && cur;

    assign n_col = row_end ? '0 : r_col + 1'b1;
    assign n_row = row_end ? (last_row ? '0 : r_row + 1'b1) : r_row;

    always_comb begin
        res_up.cell_row     = OUT_W'(r_row - 1'b1);
        res_up.cell_col     = OUT_W'(r_col);
        res_up.last_in_run  = !v_cur;
        res_cur.cell_row    = OUT_W'(r_row);
        res_cur.cell_col    = OUT_W'(r_col);
        res_cur.last_in_run = 1'b1;
        push_a = v_up ? res_up : res_cur;
        push_b = res_cur;
        n_push = 2'(v_up) + 2'(v_cur);
    end

    gbce_ram #(
        .WIDTH (OCC_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (in_acc),
        .i_waddr   (r_col),
        .i_wdata   ({self_occ, cur}),
        .i_re      (in_acc),
        .i_raddr_a (n_col),
        .i_raddr_b (COL_W'(n_col + 1'b1)),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b1;
            r_grid_width  <= RST_GRID_WIDTH;
            r_grid_height <= RST_GRID_HEIGHT;
            r_row         <= '0;
            r_col         <= '0;
        end else if (cfg_acc) begin
            case (i_cfg.index)
                CFG_ENABLE: begin
                    r_enable <= i_cfg.data[0];
                end
                CFG_WIDTH: begin
                    r_grid_width <= i_cfg.data;
                    r_row        <= '0;
                    r_col        <= '0;
                end
                CFG_HEIGHT: begin
                    r_grid_height <= i_cfg.data;
                    r_row         <= '0;
                    r_col         <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_left <= self_occ;
            if (n_push != 2'd0) begin
                r_fifo[r_wptr] <= push_a;
            end
            if (n_push == 2'd2) begin
                r_fifo[FIFO_AW'(r_wptr + 1'b1)] <= push_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (in_acc) begin
                r_wptr <= FIFO_AW'(r_wptr + n_push);
            end
            if (out_acc) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= FIFO_CW'(r_cnt + (in_acc ? FIFO_CW'(n_push) : '0) -
                              FIFO_CW'(out_acc));
        end
    end

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.cell_row    = r_fifo[r_rptr].cell_row;
    assign o_out.cell_col    = r_fifo[r_rptr].cell_col;
    assign o_out.last_in_run = r_fifo[r_rptr].last_in_run;

    `GBCE_ASSERT_NEXT(a_two_results_fill, i_clk, i_rst_n,
        in_acc && (n_push == 2'd2) && !out_acc,
        r_cnt == $past(r_cnt) + 2'd2, "two results did not both enter the queue")
    `GBCE_ASSERT_IMPL(a_run_continues, i_clk, i_rst_n,
        o_out.valid && !o_out.last_in_run,
        r_cnt >= FIFO_CW'(2), "open run without its final result queued")
    `GBCE_ASSERT_NEXT(a_col_advance, i_clk, i_rst_n,
        in_acc && !cfg_acc && !row_end,
        (r_col == $past(r_col) + 1'b1) && (r_row == $past(r_row)),
        "column did not advance within a row")

endmodule

// File: rtl/gbce_ram.sv
module gbce_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write-first: a read of the entry being written returns the new data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= (i_we && (i_waddr == i_raddr_a)) ? i_wdata : r_mem[i_raddr_a];
            r_rdata_b <= (i_we && (i_waddr == i_raddr_b)) ? i_wdata : r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb import gbce_pkg::*; ();

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1800;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gbce_in_if  in_if ();
    gbce_out_if out_if ();
    gbce_cfg_if cfg_if ();

    grid_boundary_cell_extractor_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bit      gaps_on = 1'b1;
    int      errors = 0;
    int      idle_cycles = 0;
    int      out_hold = 0;
    t_result boundary_q[$];

    logic              prev_occ [MAX_WIDTH];
    logic              older_occ[MAX_WIDTH];
    logic [ROW_W-1:0]  scan_row;
    logic [COL_W-1:0]  scan_col;
    logic              en_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    function automatic int clamp_dim(logic [SIZE_W-1:0] v, int maxv);
        if (v == '0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic void track_cell(logic [TILE_W-1:0] tile);
        int      w;
        int      h;
        int      r;
        int      c;
        int      cnt;
        int      n;
        logic    cur;
        logic    last_row;
        logic    border;
        logic    report;
        t_result found[2];
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        r = int'(scan_row);
        c = int'(scan_col);
        cur = (tile != '0);
        last_row = (r >= h - 1);
        n = 0;
        if (r >= 1 && prev_occ[c]) begin
            border = (r - 1 == 0) || (r - 1 >= h - 1) || (c == 0) || (c >= w - 1);
            report = border;
            if (!border) begin
                // left neighbor of the upper row already sits in the older buffer
                cnt = int'(older_occ[c]) + int'(cur) + int'(older_occ[c-1])
                    + int'(prev_occ[c+1]);
                report = (cnt < NEIGHBOURS);
            end
            if (report && en_reg) begin
                found[n] = '{cell_row: OUT_W'(r - 1), cell_col: OUT_W'(c), last_in_run: 1'b0};
                n++;
            end
        end
        if (last_row && cur && en_reg) begin
            found[n] = '{cell_row: OUT_W'(r), cell_col: OUT_W'(c), last_in_run: 1'b0};
            n++;
        end
        if (n > 0) found[n-1].last_in_run = 1'b1;
        for (int k = 0; k < n; k++) boundary_q.push_back(found[k]);
        older_occ[c] = prev_occ[c];
        prev_occ[c] = cur;
        if (c >= w - 1) begin
            scan_col = '0;
            scan_row = last_row ? '0 : ROW_W'(r + 1);
        end else begin
            scan_col = COL_W'(c + 1);
        end
    endfunction

    task automatic send_tile(input logic [TILE_W-1:0] tile);
        int gap;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.tile_id <= tile;
        do @(posedge i_clk); while (!in_if.ready);
        track_cell(tile);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (boundary_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
        settle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_ENABLE: begin
                en_reg = value[0];
            end
            CFG_WIDTH: begin
                width_reg = value;
                scan_row = '0;
                scan_col = '0;
            end
            CFG_HEIGHT: begin
                height_reg = value;
                scan_row = '0;
                scan_col = '0;
            end
            default: begin
            end
        endcase
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_tile(16'hFFFF);
        send_tile(16'h0001);
        send_tile(16'h0000);
    endtask

    task automatic test_full_3x3();
        logic [TILE_W-1:0] tiles[9];
        tiles = '{16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF,
                  16'h0002, 16'h1234, 16'hFFFE, 16'h0100};
        write_reg(CFG_WIDTH, 9'd3);
        write_reg(CFG_HEIGHT, 9'd3);
        foreach (tiles[i]) send_tile(tiles[i]);
    endtask

    task automatic test_zero_size();
        write_reg(CFG_WIDTH, 9'd0);
        write_reg(CFG_HEIGHT, 9'd0);
        send_tile(16'hFFFF);
        send_tile(16'h0000);
    endtask

    task automatic test_single_row();
        write_reg(CFG_WIDTH, 9'd4);
        write_reg(CFG_HEIGHT, 9'd1);
        send_tile(16'h0001);
        send_tile(16'h0000);
        send_tile(16'hFFFF);
    endtask

    task automatic test_disable();
        write_reg(CFG_WIDTH, 9'd1);
        write_reg(CFG_HEIGHT, 9'd1);
        write_reg(CFG_ENABLE, 9'd0);
        send_tile(16'hFFFF);
        send_tile(16'h8001);
        write_reg(CFG_ENABLE, 9'd1);
        send_tile(16'h0001);
    endtask

    task automatic test_unknown_index();
        write_reg(CFG_UNUSED, 9'h1FF);
        send_tile(16'h00FF);
    endtask

    task automatic test_random_grids();
        int                sent;
        int                phase;
        int                mode;
        int                cells;
        int                density;
        int                pick;
        logic [SIZE_W-1:0] w_raw;
        logic [SIZE_W-1:0] h_raw;
        logic [TILE_W-1:0] tile;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            mode = (phase < 2) ? phase : $urandom_range(2, 21);
            if (mode == 0) begin
                pick = $urandom_range(0, 2);
                w_raw = (phase == 0) ? 9'd511 : (pick == 0 ? 9'd256 : (pick == 1 ? 9'd257 : 9'd511));
                h_raw = SIZE_W'($urandom_range(0, 2));
            end else if (mode == 1) begin
                w_raw = SIZE_W'($urandom_range(1, 2));
                pick = $urandom_range(0, 2);
                h_raw = (phase == 1) ? 9'd511 : (pick == 0 ? 9'd256 : (pick == 1 ? 9'd300 : 9'd511));
            end else begin
                w_raw = SIZE_W'($urandom_range(0, 12));
                h_raw = SIZE_W'($urandom_range(0, 10));
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) write_reg(CFG_UNUSED, SIZE_W'($urandom_range(0, 511)));
            write_reg(CFG_ENABLE, ($urandom_range(0, 7) != 0) ? 9'd1 : 9'd0);
            write_reg(CFG_WIDTH, w_raw);
            write_reg(CFG_HEIGHT, h_raw);
            cells = clamp_dim(w_raw, MAX_WIDTH) * clamp_dim(h_raw, MAX_HEIGHT);
            if (mode >= 2) begin
                cells = cells * $urandom_range(1, 3);
                // drop the tail of the last grid now and then
                if ($urandom_range(0, 3) == 0) cells = $urandom_range(1, cells);
            end
            density = $urandom_range(40, 100);
            for (int i = 0; i < cells; i++) begin
                if ($urandom_range(1, 100) > density) begin
                    tile = '0;
                end else begin
                    pick = $urandom_range(0, 3);
                    if (pick == 0) tile = TILE_W'(1) << $urandom_range(0, TILE_W - 1);
                    else if (pick == 1) tile = 16'hFFFF;
                    else tile = TILE_W'($urandom_range(1, 16'hFFFF));
                end
                send_tile(tile);
            end
            sent += cells;
            phase++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        int      stall;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_hold <= 0;
        end else if (out_if.valid && out_if.ready) begin
            if (boundary_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual row %0d col %0d last %0b",
                         $time, out_if.cell_row, out_if.cell_col, out_if.last_in_run);
            end else begin
                want = boundary_q.pop_front();
                if (out_if.cell_row !== want.cell_row) begin
                    errors++;
                    $display("%0t: cell_row expected %0d actual %0d",
                             $time, want.cell_row, out_if.cell_row);
                end
                if (out_if.cell_col !== want.cell_col) begin
                    errors++;
                    $display("%0t: cell_col expected %0d actual %0d",
                             $time, want.cell_col, out_if.cell_col);
                end
                if (out_if.last_in_run !== want.last_in_run) begin
                    errors++;
                    $display("%0t: last_in_run expected %0b actual %0b",
                             $time, want.last_in_run, out_if.last_in_run);
                end
            end
            stall = gaps_on ? $urandom_range(0, 6) : 0;
            out_hold <= stall;
            out_if.ready <= (stall == 0);
        end else if (out_hold > 1) begin
            out_hold <= out_hold - 1;
        end else begin
            out_hold <= 0;
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        in_if.valid   = 1'b0;
        in_if.tile_id = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_ENABLE;
        cfg_if.data   = '0;
        en_reg        = 1'b1;
        width_reg     = RST_GRID_WIDTH;
        height_reg    = RST_GRID_HEIGHT;
        scan_row      = '0;
        scan_col      = '0;
        foreach (prev_occ[i]) begin
            prev_occ[i]  = 1'b0;
            older_occ[i] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_full_3x3();
        test_zero_size();
        test_single_row();
        test_disable();
        test_unknown_index();
        test_random_grids();

        settle();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
